@@ rtl/bsc_pkg.sv @@
// Package for the barometric sensor compensation block: item types,
// register indexes, sequencer state codes and default constants.
// Used by every module of the block.
`default_nettype none
package bsc_pkg;

    localparam int FRAC_BITS_DEF  = 32;
    localparam int STATE_BITS     = 40;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int RAW_W          = 24;
    localparam int OUT_W          = 24;
    localparam int FX_W           = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [23:0] SCALE_RESET = 24'd524288;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LAST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRS_SCALE  = 3'd4;

    localparam logic [1:0] KIND_TEMP = 2'd0;
    localparam logic [1:0] KIND_PRS  = 2'd1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [RAW_W-1:0] raw_word;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] comp_value;
        logic                    is_pressure;
        logic                    saturated;
    } t_out_item;

    // classified work item handed from front to back
    typedef struct packed {
        logic             is_prs;
        logic [RAW_W-1:0] raw_word;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DIV_DONE,
        S_MUL,
        S_ADD,
        S_FINAL,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ rtl/bsc_front.sv @@
// Front part: accepts input items, classifies temperature or pressure,
// and queues jobs for the back part. Depends on bsc_pkg.
`default_nettype none
module bsc_front
    import bsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_job_valid,
    input  wire logic     i_job_take,
    output t_job          o_job
);
    t_job r_q [QUEUE_DEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, n_rd, r_wr, n_wr;
    logic       w_push, w_pop;
    t_job       w_job;

    always_comb begin
        w_job.raw_word = i_in_item.raw_word;
        priority if (i_in_item.kind == KIND_TEMP) w_job.is_prs = 1'b0;
        else if (i_in_item.kind == KIND_PRS)      w_job.is_prs = 1'b1;
        else                                      w_job.is_prs = i_in_item.raw_word[0];
    end

    assign o_in_stall  = (r_cnt == 2'(QUEUE_DEPTH));
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
        n_rd  = w_pop  ? ~r_rd : r_rd;
        n_wr  = w_push ? ~r_wr : r_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            r_wr  <= n_wr;
        end
        if (w_push) r_q[r_wr] <= w_job;
    end
endmodule
`default_nettype wire

@@ rtl/bsc_back.sv @@
// Back part: scales the raw word with a bit-serial divider, then runs the
// polynomial on one shared 64x64 multiplier built from 32x32 partial products.
// Depends on bsc_pkg.
`default_nettype none
module bsc_back
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    output logic                   o_job_take,
    input  wire t_job              i_job,
    input  wire logic [CFG_W-1:0]  i_cal_first,
    input  wire logic [CFG_W-1:0]  i_cal_second,
    input  wire logic [15:0]       i_cal_last,
    input  wire logic [23:0]       i_temp_scale,
    input  wire logic [23:0]       i_prs_scale,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item
);
    localparam int DIVN_W = RAW_W + FRAC_BITS;      // dividend width
    localparam int DCNT_W = $clog2(DIVN_W + 1);
    localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
    localparam logic signed [FX_W-1:0] ST_MAX = FX_W'(64'sd1 <<< (STATE_BITS-1)) - 1;
    localparam logic signed [FX_W-1:0] ST_MIN = -FX_W'(64'sd1 <<< (STATE_BITS-1));

    t_state r_state, n_state;

    // divider
    logic [DIVN_W-1:0] r_quo;
    logic [24:0]       r_rem;
    logic [23:0]       r_div;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_neg;

    // job and datapath
    logic                   r_is_prs;
    logic [2:0]             r_step;
    logic [1:0]             r_pp;
    logic signed [FX_W-1:0] r_p, r_acc, r_accb, r_prod;
    logic                   r_sat;
    logic [127:0]           r_mag;
    logic                   r_mneg;
    logic [FX_W-1:0]        r_ma, r_mb;
    t_out_item              r_out;
    logic                   r_ovalid;
    logic signed [FX_W-1:0] r_temp;

    // coefficient extraction
    logic [7:0] b [18];
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i]   = i_cal_first[8*(7-i) +: 8];
            b[i+8] = i_cal_second[8*(7-i) +: 8];
        end
        b[16] = i_cal_last[15:8];
        b[17] = i_cal_last[7:0];
    end

    function automatic logic signed [FX_W-1:0] fx(input logic signed [19:0] c, input int sh);
        fx = FX_W'(c) <<< sh;
    endfunction

    logic signed [FX_W-1:0] c0h, c1, c00, c10, c01, c11, c20, c21, c30;
    always_comb begin
        c0h = fx(20'(signed'({b[0], b[1][7:4]})), FRAC_BITS - 1);
        c1  = fx(20'(signed'({b[1][3:0], b[2]})), FRAC_BITS);
        c00 = fx(signed'({b[3], b[4], b[5][7:4]}), FRAC_BITS);
        c10 = fx(signed'({b[5][3:0], b[6], b[7]}), FRAC_BITS);
        c01 = fx(20'(signed'({b[8], b[9]})), FRAC_BITS);
        c11 = fx(20'(signed'({b[10], b[11]})), FRAC_BITS);
        c20 = fx(20'(signed'({b[12], b[13]})), FRAC_BITS);
        c21 = fx(20'(signed'({b[14], b[15]})), FRAC_BITS);
        c30 = fx(20'(signed'({b[16], b[17]})), FRAC_BITS);
    end

    // Step schedule. Temp: T*c1 + c0/2.
    // Pressure: a=c20+p*c30; a=c10+p*a; a=c00+p*a; b=c11+p*c21; b=c01+p*b;
    // r=a+T*b. Multiplier operands are loaded ahead; only the addend is picked here.
    logic signed [FX_W-1:0] w_addend;
    always_comb begin
        w_addend = '0;
        if (!r_is_prs) begin
            w_addend = c0h;
        end else begin
            unique case (r_step)
                3'd0: w_addend = c20;
                3'd1: w_addend = c10;
                3'd2: w_addend = c00;
                3'd3: w_addend = c11;
                3'd4: w_addend = c01;
                3'd5: w_addend = r_acc;
                default: ;
            endcase
        end
    end

    function automatic logic [FX_W-1:0] mag(input logic signed [FX_W-1:0] v);
        mag = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
    endfunction

    // one 32x32 partial product per cycle
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_mnext;
    always_comb begin
        w_pa = r_pp[0] ? r_ma[63:32] : r_ma[31:0];
        w_pb = r_pp[1] ? r_mb[63:32] : r_mb[31:0];
        w_pp = 64'(w_pa) * 64'(w_pb);
        w_mnext = r_mag + (128'(w_pp) << (32 * (32'(r_pp[0]) + 32'(r_pp[1]))));
    end

    // product scaling and saturation, on the sum that includes the last term
    logic [127:0]           w_sh;
    logic signed [FX_W-1:0] w_mres;
    logic                   w_msat;
    always_comb begin
        w_sh   = w_mnext >> FRAC_BITS;
        w_msat = 1'b0;
        if (w_sh[127:64] != '0) begin
            w_msat = 1'b1; w_mres = r_mneg ? FX_MIN : FX_MAX;
        end else if (r_mneg) begin
            if (w_sh[63:0] > 64'h8000_0000_0000_0000) begin
                w_msat = 1'b1; w_mres = FX_MIN;
            end else w_mres = -signed'(w_sh[63:0]);
        end else if (w_sh[63]) begin
            w_msat = 1'b1; w_mres = FX_MAX;
        end else w_mres = signed'(w_sh[63:0]);
    end

    // saturating add of product register and addend
    logic signed [FX_W:0]   w_sum;
    logic signed [FX_W-1:0] w_sres;
    logic                   w_ssat;
    always_comb begin
        w_sum  = (FX_W+1)'(r_prod) + (FX_W+1)'(w_addend);
        w_ssat = (w_sum[FX_W] != w_sum[FX_W-1]);
        w_sres = w_ssat ? (w_sum[FX_W] ? FX_MIN : FX_MAX) : w_sum[FX_W-1:0];
    end

    // final integer conversion
    logic [FX_W-1:0] w_fm;
    logic            w_fsat;
    logic [OUT_W-1:0] w_fv;
    always_comb begin
        w_fm   = mag(r_acc) >> FRAC_BITS;
        w_fsat = 1'b0;
        if (r_acc[FX_W-1]) begin
            if (w_fm > 64'd8388608) begin w_fsat = 1'b1; w_fm = 64'd8388608; end
            w_fv = OUT_W'(-w_fm);
        end else begin
            if (w_fm > 64'd8388607) begin w_fsat = 1'b1; w_fm = 64'd8388607; end
            w_fv = OUT_W'(w_fm);
        end
    end

    logic [24:0]       w_trial;
    logic [24:0]       w_rem2;
    logic signed [FX_W-1:0] w_scaled;
    logic [23:0]       w_raw_mag;
    logic [23:0]       w_dsel;
    always_comb begin
        w_rem2  = {r_rem[23:0], r_quo[DIVN_W-1]};
        w_trial = w_rem2 - {1'b0, r_div};
        w_raw_mag = i_job.raw_word[RAW_W-1] ? 24'(-i_job.raw_word) : i_job.raw_word;
        w_dsel  = i_job.is_prs ? i_prs_scale : i_temp_scale;
        if (w_dsel == '0) w_dsel = 24'd1;
        // quotient magnitude is at most 2^(23+FRAC_BITS), inside 64 bits
        w_scaled = r_neg ? -FX_W'(r_quo) : FX_W'(r_quo);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_job_valid) n_state = S_DIV;
            S_DIV:      if (r_dcnt == '0) n_state = S_DIV_DONE;
            S_DIV_DONE: n_state = S_MUL;
            S_MUL:      if (r_pp == 2'd3) n_state = S_ADD;
            S_ADD:      n_state = (!r_is_prs || r_step == 3'd5) ? S_FINAL : S_MUL;
            S_FINAL:    n_state = S_OUT;
            S_OUT:      if (!r_ovalid) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    assign o_job_take  = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_temp   <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            if (r_state == S_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_DIV_DONE && !r_is_prs)
                r_temp <= (w_scaled > ST_MAX) ? ST_MAX : (w_scaled < ST_MIN ? ST_MIN : w_scaled);
        end

        unique case (r_state)
            S_IDLE: begin
                r_is_prs <= i_job.is_prs;
                r_neg    <= i_job.raw_word[RAW_W-1];
                r_quo    <= {w_raw_mag, FRAC_BITS'(0)};
                r_rem    <= '0;
                r_div    <= w_dsel;
                r_dcnt   <= DCNT_W'(DIVN_W - 1);
                r_sat    <= 1'b0;
                r_step   <= '0;
            end
            S_DIV: begin
                if (!w_trial[24]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[DIVN_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_quo <= {r_quo[DIVN_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_DIV_DONE: begin
                r_p  <= w_scaled;
                r_pp <= '0;
                r_mag <= '0;
                r_ma  <= mag(r_is_prs ? w_scaled : c1);
                r_mb  <= mag(r_is_prs ? c30 : w_scaled);
                r_mneg <= r_is_prs ? (w_scaled[FX_W-1] ^ c30[FX_W-1])
                                   : (c1[FX_W-1] ^ w_scaled[FX_W-1]);
            end
            S_MUL: begin
                r_mag <= w_mnext;
                r_pp  <= r_pp + 1'b1;
            end
            S_ADD: ;
            S_FINAL: ;
            S_OUT: begin
                // result register loads only once the previous item has left
                if (!r_ovalid) begin
                    r_out.comp_value  <= signed'(w_fv);
                    r_out.is_pressure <= r_is_prs;
                    r_out.saturated   <= r_sat | w_fsat;
                end
            end
            default: ;
        endcase

        // product register loads with the last partial product
        if (r_state == S_MUL && r_pp == 2'd3) begin
            r_prod <= w_mres;
            r_sat  <= r_sat | w_msat;
        end
        if (r_state == S_ADD) begin
            r_sat <= r_sat | w_ssat;
            if (r_is_prs && (r_step == 3'd3 || r_step == 3'd4)) r_accb <= w_sres;
            else r_acc <= w_sres;
            r_step <= r_step + 1'b1;
            r_pp   <= '0;
            r_mag  <= '0;
            // operands of the next step
            unique case (r_step)
                3'd0, 3'd1: begin
                    r_ma <= mag(r_p); r_mb <= mag(w_sres);
                    r_mneg <= r_p[FX_W-1] ^ w_sres[FX_W-1];
                end
                3'd2: begin
                    r_ma <= mag(r_p); r_mb <= mag(c21);
                    r_mneg <= r_p[FX_W-1] ^ c21[FX_W-1];
                end
                3'd3: begin
                    r_ma <= mag(r_p); r_mb <= mag(w_sres);
                    r_mneg <= r_p[FX_W-1] ^ w_sres[FX_W-1];
                end
                3'd4: begin
                    r_ma <= mag(r_temp); r_mb <= mag(w_sres);
                    r_mneg <= r_temp[FX_W-1] ^ w_sres[FX_W-1];
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/baro_sensor_compensation.sv @@
// Top level of the barometric sensor compensation block: configuration
// registers, front classifier, job queue and compensation back end.
// Depends on bsc_pkg, bsc_front and bsc_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------
//   input    | i_in_valid / o_in_stall | i_in_item  (kind, raw_word)
//   output   | o_out_valid / i_out_stall | o_out_item (comp_value,...)
//   config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// The back end takes a job, runs restoring division (one quotient bit per
// cycle), loads the multiplier, performs each multiply-add as four 32x32
// partial products and one saturating add, then converts and presents the
// result. The division loop takes most of the time. The front queue holds two
// items, so the input side can accept up to two items while the back end
// works; a result waiting on a stall holds the back end in its output state
// once the next result is ready to be presented.
// Reset is synchronous, active low; it clears the stored temperature and
// restores register defaults.
`default_nettype none
module baro_sensor_compensation
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    logic [CFG_W-1:0] r_cal_first, r_cal_second;
    logic [15:0]      r_cal_last;
    logic [23:0]      r_temp_scale, r_prs_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_first  <= '0;
            r_cal_second <= '0;
            r_cal_last   <= '0;
            r_temp_scale <= SCALE_RESET;
            r_prs_scale  <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAL_FIRST:  r_cal_first  <= i_cfg_data;
                REG_CAL_SECOND: r_cal_second <= i_cfg_data;
                REG_CAL_LAST:   r_cal_last   <= i_cfg_data[15:0];
                REG_TEMP_SCALE: r_temp_scale <= i_cfg_data[23:0];
                REG_PRS_SCALE:  r_prs_scale  <= i_cfg_data[23:0];
                default: ;  // writes beyond the map are dropped
            endcase
        end
    end

    logic w_job_valid, w_job_take;
    t_job w_job;

    bsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take),
        .o_job       (w_job)
    );

    bsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .o_job_take   (w_job_take),
        .i_job        (w_job),
        .i_cal_first  (r_cal_first),
        .i_cal_second (r_cal_second),
        .i_cal_last   (r_cal_last),
        .i_temp_scale (r_temp_scale),
        .i_prs_scale  (r_prs_scale),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );
endmodule
`default_nettype wire

@@ rtl/bsc_checker.sv @@
// Port-level checker for baro_sensor_compensation, attached by bind.
// Depends on bsc_pkg.
`default_nettype none
module bsc_checker
    import bsc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed under stall");
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
    a_not_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown(o_out_item))
        else $error("unknown bits in a valid result");
endmodule

bind baro_sensor_compensation bsc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
